>>> sv/ghsp_pkg.sv
// Types, sizes and codes shared by the slot pool modules.
`default_nettype none
package ghsp_pkg;

	localparam int SLOTS    = 64;
	localparam int GEN_BITS = 16;
	localparam int IDX_W    = $clog2(SLOTS);
	localparam int CNT_W    = $clog2(SLOTS + 1);

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_RESOLVE = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic [1:0]          action;
		logic [IDX_W-1:0]    slot_index;
		logic [GEN_BITS-1:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [IDX_W-1:0]    granted_index;
		logic [GEN_BITS-1:0] granted_generation;
	} rsp_t;

	typedef struct packed {
		logic                busy;
		logic [GEN_BITS-1:0] gen;
	} slot_entry_t;

	typedef struct packed {
		logic [IDX_W-1:0]    idx;
		logic [GEN_BITS-1:0] gen;
	} fifo_entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		slot_entry_t      data;
	} slot_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		fifo_entry_t      data;
	} fifo_wr_t;

endpackage
`default_nettype wire

>>> sv/generational_handle_slot_pool_core.sv
// Generational handle slot pool: request sequencing, counters and response register.
`default_nettype none
// A request is taken on its transfer edge, which reads the slot memory at the request's
// index and the free-list memory at its head; the decide stage then decides, writes both
// memories back and loads the response register. The next transfer is taken once the
// decide stage is empty, so the pool takes no new request before the last one is retired;
// a response left waiting holds the following request in the decide stage. Slots start free
// at generation 1 and are tracked by a fill count, so no clearing pass follows reset.
module generational_handle_slot_pool_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ghsp_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ghsp_pkg::rsp_t  rsp
);
	import ghsp_pkg::*;

	logic                accept;
	logic                retire;
	logic                valid_s1;
	req_t                req_s1;
	slot_entry_t         slot_rd;
	fifo_entry_t         fifo_rd;
	slot_wr_t            slot_wr;
	fifo_wr_t            fifo_wr;
	logic [IDX_W-1:0]    head_q;
	logic [IDX_W-1:0]    head_d;
	logic [CNT_W-1:0]    fifo_count_q;
	logic [CNT_W-1:0]    fifo_count_d;
	logic [CNT_W-1:0]    fresh_q;
	logic [CNT_W-1:0]    fresh_d;
	logic                idx_live;
	logic [GEN_BITS-1:0] gen_inc;
	logic [GEN_BITS-1:0] gen_next;
	rsp_t                rsp_d;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	assign req_stall = valid_s1;
	assign accept    = req_valid && !req_stall;
	assign retire    = valid_s1 && (!rsp_valid_q || !rsp_stall);

	ghsp_slot_ram u_slot_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (req.slot_index),
		.wr      (slot_wr),
		.rd_data (slot_rd)
	);

	ghsp_free_ram u_free_ram (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (head_q),
		.wr      (fifo_wr),
		.rd_data (fifo_rd)
	);

	assign idx_live = CNT_W'(req_s1.slot_index) < fresh_q;
	assign gen_inc  = slot_rd.gen + 1'b1;
	assign gen_next = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

	always_comb begin
		rsp_d        = '{status: ST_BAD, granted_index: '0, granted_generation: '0};
		slot_wr      = '0;
		fifo_wr      = '0;
		head_d       = head_q;
		fifo_count_d = fifo_count_q;
		fresh_d      = fresh_q;
		unique case (req_s1.action)
			ACT_ALLOC: begin
				if (fifo_count_q != '0) begin
					rsp_d = '{status: ST_OK, granted_index: fifo_rd.idx,
						granted_generation: fifo_rd.gen};
					head_d       = head_q + 1'b1;
					fifo_count_d = fifo_count_q - 1'b1;
				end else if (fresh_q != CNT_W'(SLOTS)) begin
					rsp_d = '{status: ST_OK, granted_index: fresh_q[IDX_W-1:0],
						granted_generation: GEN_BITS'(1)};
					fresh_d = fresh_q + 1'b1;
				end else begin
					rsp_d.status = ST_FULL;
				end
				slot_wr.en        = (rsp_d.status == ST_OK);
				slot_wr.addr      = rsp_d.granted_index;
				slot_wr.data.busy = 1'b1;
				slot_wr.data.gen  = rsp_d.granted_generation;
			end
			ACT_RELEASE: begin
				rsp_d.granted_index = req_s1.slot_index;
				if (idx_live && !slot_rd.busy) begin
					rsp_d.granted_generation = slot_rd.gen;
				end else if (idx_live) begin
					rsp_d.status             = ST_OK;
					rsp_d.granted_generation = gen_next;
					slot_wr.en               = 1'b1;
					slot_wr.addr             = req_s1.slot_index;
					slot_wr.data.busy        = 1'b0;
					slot_wr.data.gen         = gen_next;
					if (fifo_count_q != CNT_W'(SLOTS)) begin
						fifo_wr.en       = 1'b1;
						fifo_wr.addr     = head_q + fifo_count_q[IDX_W-1:0];
						fifo_wr.data.idx = req_s1.slot_index;
						fifo_wr.data.gen = gen_next;
						fifo_count_d     = fifo_count_q + 1'b1;
					end
				end
			end
			ACT_RESOLVE: begin
				rsp_d.granted_index = req_s1.slot_index;
				if (idx_live) begin
					rsp_d.granted_generation = slot_rd.gen;
					if (req_s1.handle_generation != '0 && slot_rd.busy
							&& slot_rd.gen == req_s1.handle_generation) begin
						rsp_d.status = ST_OK;
					end
				end
			end
			default: begin
				rsp_d.status = ST_BAD;
			end
		endcase
		if (!retire) begin
			slot_wr.en = 1'b0;
			fifo_wr.en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			head_q       <= '0;
			fifo_count_q <= '0;
			fresh_q      <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				rsp_valid_q  <= 1'b1;
				head_q       <= head_d;
				fifo_count_q <= fifo_count_d;
				fresh_q      <= fresh_d;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (retire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count_q <= fresh_q)
		else $error("free-list count exceeds slots handed out");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> valid_s1)
		else $error("transfer did not reach the decide stage");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_FULL) |->
		(fresh_q == CNT_W'(SLOTS) && fifo_count_q == '0))
		else $error("full status while a slot is available");

	a_fifo_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_wr.en |-> (slot_wr.en && !slot_wr.data.busy))
		else $error("free-list push without freeing the slot");

endmodule
`default_nettype wire

>>> sv/ghsp_slot_ram.sv
// Slot state memory: busy flag and generation per slot, registered read.
`default_nettype none
module ghsp_slot_ram (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [ghsp_pkg::IDX_W-1:0]   rd_addr,
	input  ghsp_pkg::slot_wr_t           wr,
	output ghsp_pkg::slot_entry_t        rd_data
);
	import ghsp_pkg::*;

	slot_entry_t mem [SLOTS];
	slot_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

>>> sv/ghsp_free_ram.sv
// Free-list memory: queued slot index with the generation it was freed at.
`default_nettype none
module ghsp_free_ram (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [ghsp_pkg::IDX_W-1:0]   rd_addr,
	input  ghsp_pkg::fifo_wr_t           wr,
	output ghsp_pkg::fifo_entry_t        rd_data
);
	import ghsp_pkg::*;

	fifo_entry_t mem [SLOTS];
	fifo_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire
